FILE: sv/ndrth_pkg.sv
`timescale 1ns / 1ps

package ndrth_pkg;

    localparam int COORD_W = 28;
    localparam int ID_W    = 16;
    localparam int DIST_W  = 31;
    localparam int LIFT_W  = 24;
    localparam int AD_W    = 59;
    localparam int REM_W   = 91;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_VERTEX = 2'd1;
    localparam logic [1:0] MODE_COMMIT = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    localparam logic [1:0] SLOT_COUNT = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_QUERY = 2'd2;

    localparam logic CFG_PROBE_LIFT = 1'b0;
    localparam logic CFG_MAX_DIST   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } tri_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W:0]   y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic              cand;
        logic [REM_W-1:0]  rem;
        logic [AD_W-1:0]   ad;
        logic [DIST_W-1:0] q;
        logic [ID_W-1:0]   id;
    } div_beat_t;

endpackage

FILE: sv/ndrth_ram.sv
`timescale 1ns / 1ps

module ndrth_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/ndrth_geom.sv
`timescale 1ns / 1ps

module ndrth_geom (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_vld,
    input  ndrth_pkg::tri_t                 tri_in,
    input  logic [ndrth_pkg::ID_W-1:0]      in_id,
    input  ndrth_pkg::point_t               pt,
    output logic                            out_vld,
    output ndrth_pkg::div_beat_t            out_beat
);

    localparam int DW = ndrth_pkg::COORD_W + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int TW = ndrth_pkg::REM_W + 1;

    logic [6:0] vld_reg;

    logic signed [DW-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [DW-1:0] sx1_reg, sz1_reg;
    logic signed [DW:0]   sy1_reg;
    logic [ndrth_pkg::ID_W-1:0] id_reg [6];

    logic signed [PW-1:0] pd0_reg, pd1_reg, pu0_reg, pu1_reg, pv0_reg, pv1_reg;
    logic signed [PW-1:0] pnx0_reg, pnx1_reg, pnz0_reg, pnz1_reg;
    logic signed [DW-1:0] sx2_reg, sz2_reg, sx3_reg, sz3_reg;
    logic signed [DW:0]   sy2_reg, sy3_reg;

    logic signed [SW-1:0] det_reg, u_reg, v_reg, nx_reg, nz_reg;

    logic                         ok4_reg, dneg4_reg;
    logic [ndrth_pkg::AD_W-1:0]   ad4_reg;
    logic signed [DW+31:0]        mxl_reg, mzl_reg;
    logic signed [DW+DW-1:0]      mxh_reg, mzh_reg;
    logic signed [DW+32:0]        myl_reg;
    logic signed [DW+DW:0]        myh_reg;

    logic                         ok5_reg, dneg5_reg, ok6_reg, dneg6_reg;
    logic [ndrth_pkg::AD_W-1:0]   ad5_reg, ad6_reg;
    logic signed [TW-1:0]         t1_reg, t2_reg, t3_reg, tn_reg;

    logic                         ok4_c;
    logic signed [SW:0]           uv_c;
    logic                         tneg_c, tzero_c;
    logic [ndrth_pkg::REM_W-1:0]  mag_c;
    logic signed [TW-1:0]         negtn_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    always_comb
    begin
        uv_c  = (SW + 1)'(u_reg) + (SW + 1)'(v_reg);
        ok4_c = 1'b0;
        if (det_reg > 0)
        begin
            ok4_c = !(u_reg < 0 || u_reg > det_reg || v_reg < 0
                      || uv_c > (SW + 1)'(det_reg));
        end
        else if (det_reg < 0)
        begin
            ok4_c = !(u_reg > 0 || u_reg < det_reg || v_reg > 0
                      || uv_c < (SW + 1)'(det_reg));
        end
        tneg_c  = tn_reg[TW-1];
        tzero_c = (tn_reg == '0);
        negtn_c = -tn_reg;
        mag_c   = tneg_c ? negtn_c[ndrth_pkg::REM_W-1:0] : tn_reg[ndrth_pkg::REM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        e1x_reg <= DW'(tri_in.bx) - DW'(tri_in.ax);
        e1y_reg <= DW'(tri_in.by) - DW'(tri_in.ay);
        e1z_reg <= DW'(tri_in.bz) - DW'(tri_in.az);
        e2x_reg <= DW'(tri_in.cx) - DW'(tri_in.ax);
        e2y_reg <= DW'(tri_in.cy) - DW'(tri_in.ay);
        e2z_reg <= DW'(tri_in.cz) - DW'(tri_in.az);
        sx1_reg <= DW'(pt.x) - DW'(tri_in.ax);
        sy1_reg <= (DW + 1)'(pt.y) - (DW + 1)'(tri_in.ay);
        sz1_reg <= DW'(pt.z) - DW'(tri_in.az);
        id_reg[0] <= in_id;
        for (int k = 1; k < 6; k++)
        begin
            id_reg[k] <= id_reg[k-1];
        end

        pd0_reg  <= e1z_reg * e2x_reg;
        pd1_reg  <= e1x_reg * e2z_reg;
        pu0_reg  <= sz1_reg * e2x_reg;
        pu1_reg  <= sx1_reg * e2z_reg;
        pv0_reg  <= sx1_reg * e1z_reg;
        pv1_reg  <= sz1_reg * e1x_reg;
        pnx0_reg <= e1y_reg * e2z_reg;
        pnx1_reg <= e1z_reg * e2y_reg;
        pnz0_reg <= e1x_reg * e2y_reg;
        pnz1_reg <= e1y_reg * e2x_reg;
        sx2_reg  <= sx1_reg;
        sy2_reg  <= sy1_reg;
        sz2_reg  <= sz1_reg;

        det_reg <= SW'(pd0_reg) - SW'(pd1_reg);
        u_reg   <= SW'(pu0_reg) - SW'(pu1_reg);
        v_reg   <= SW'(pv0_reg) - SW'(pv1_reg);
        nx_reg  <= SW'(pnx0_reg) - SW'(pnx1_reg);
        nz_reg  <= SW'(pnz0_reg) - SW'(pnz1_reg);
        sx3_reg <= sx2_reg;
        sy3_reg <= sy2_reg;
        sz3_reg <= sz2_reg;

        ok4_reg   <= ok4_c;
        dneg4_reg <= det_reg[SW-1];
        ad4_reg   <= det_reg[SW-1] ? ndrth_pkg::AD_W'(-det_reg) : ndrth_pkg::AD_W'(det_reg);
        mxl_reg   <= sx3_reg * $signed({1'b0, nx_reg[29:0]});
        mxh_reg   <= sx3_reg * $signed(nx_reg[SW-1:30]);
        myl_reg   <= sy3_reg * $signed({1'b0, det_reg[29:0]});
        myh_reg   <= sy3_reg * $signed(det_reg[SW-1:30]);
        mzl_reg   <= sz3_reg * $signed({1'b0, nz_reg[29:0]});
        mzh_reg   <= sz3_reg * $signed(nz_reg[SW-1:30]);

        ok5_reg   <= ok4_reg;
        dneg5_reg <= dneg4_reg;
        ad5_reg   <= ad4_reg;
        t1_reg    <= (TW'(mxh_reg) <<< 30) + TW'(mxl_reg);
        t2_reg    <= (TW'(myh_reg) <<< 30) + TW'(myl_reg);
        t3_reg    <= (TW'(mzh_reg) <<< 30) + TW'(mzl_reg);

        ok6_reg   <= ok5_reg;
        dneg6_reg <= dneg5_reg;
        ad6_reg   <= ad5_reg;
        tn_reg    <= t1_reg + t2_reg + t3_reg;

        out_beat.cand <= ok6_reg && (tzero_c || (tneg_c == dneg6_reg))
                         && (mag_c < {ad6_reg, {ndrth_pkg::DIST_W{1'b0}}});
        out_beat.rem  <= mag_c;
        out_beat.ad   <= ad6_reg;
        out_beat.q    <= '0;
        out_beat.id   <= id_reg[5];
    end

    assign out_vld = vld_reg[6];

endmodule

FILE: sv/ndrth_div_cell.sv
`timescale 1ns / 1ps

module ndrth_div_cell #(
    parameter int BIT = 30
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_vld,
    input  ndrth_pkg::div_beat_t in_beat,
    output logic                 out_vld,
    output ndrth_pkg::div_beat_t out_beat
);

    logic                              vld_reg;
    ndrth_pkg::div_beat_t              beat_reg, beat_next;
    logic [ndrth_pkg::REM_W-1:0]       d_c;
    logic                              ge_c;

    always_comb
    begin
        d_c       = ndrth_pkg::REM_W'(in_beat.ad) << BIT;
        ge_c      = in_beat.rem >= d_c;
        beat_next = in_beat;
        if (ge_c)
        begin
            beat_next.rem    = in_beat.rem - d_c;
            beat_next.q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_vld  = vld_reg;
    assign out_beat = beat_reg;

endmodule

FILE: sv/nearest_downward_ray_triangle_hit.sv
`timescale 1ns / 1ps

// Clear, vertex write and commit items each produce one result beat.
// A query lifts the point by probe_lift, casts a ray straight down and tests every
// stored triangle, one per cycle, through a seven-stage geometry pipeline and a row of
// 31 restoring division cells that each settle one bit of the hit distance. A query
// over N stored triangles puts out its answer beat once the scan of the corner memories
// has issued all N triangles and the geometry pipeline and cell row have drained; over
// an empty table it goes straight from scan to drain to done. The input stays stalled until
// the answer beat is out. The stores are not cleared after reset, so there is no
// startup pass.
module nearest_downward_ray_triangle_hit #(
    parameter int MAX_TRIANGLES = 1024,
    parameter int FRAC_BITS     = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             mode,
    input  logic [1:0]                             vertex_slot,
    input  logic signed [ndrth_pkg::COORD_W-1:0]   pos_x,
    input  logic signed [ndrth_pkg::COORD_W-1:0]   pos_y,
    input  logic signed [ndrth_pkg::COORD_W-1:0]   pos_z,
    input  logic [ndrth_pkg::ID_W-1:0]             entry_id,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [1:0]                             status,
    output logic                                   hit,
    output logic [ndrth_pkg::ID_W-1:0]             hit_id,
    output logic [ndrth_pkg::DIST_W-1:0]           hit_distance,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_index,
    input  logic [ndrth_pkg::DIST_W-1:0]           cfg_data
);

    localparam int AW      = MAX_TRIANGLES > 1 ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CW      = $clog2(MAX_TRIANGLES + 1);
    localparam int LIFT_UP = FRAC_BITS > 16 ? FRAC_BITS - 16 : 0;
    localparam int LIFT_DN = FRAC_BITS < 16 ? 16 - FRAC_BITS : 0;
    localparam int NCELL   = ndrth_pkg::DIST_W;

    ndrth_pkg::state_t                  state_reg, state_next;
    logic [CW-1:0]                      scan_reg, scan_next;
    logic [CW-1:0]                      pend_reg, pend_next;
    logic [CW-1:0]                      count_reg;
    logic [15:0]                        probe_lift_reg;
    logic [ndrth_pkg::DIST_W-1:0]       max_dist_reg;
    ndrth_pkg::point_t                  pt_reg;
    logic [ndrth_pkg::DIST_W-1:0]       best_reg;
    logic                               best_hit_reg;
    logic [ndrth_pkg::ID_W-1:0]         best_id_reg;
    logic                               rd_vld_reg;

    logic                               out_valid_reg;
    logic [1:0]                         status_reg;
    logic                               hit_reg;
    logic [ndrth_pkg::ID_W-1:0]         hit_id_reg;
    logic [ndrth_pkg::DIST_W-1:0]       hit_dist_reg;

    logic                               in_acc, out_free, full, issue, exit_vld, take;
    logic                               load_item, load_query, wr_vertex;
    logic [ndrth_pkg::LIFT_W-1:0]       lift;

    logic [ndrth_pkg::COORD_W-1:0]      rd_x [3];
    logic [ndrth_pkg::COORD_W-1:0]      rd_y [3];
    logic [ndrth_pkg::COORD_W-1:0]      rd_z [3];
    logic [ndrth_pkg::ID_W-1:0]         rd_id;
    ndrth_pkg::tri_t                    tri_rd;

    logic                               chain_vld  [NCELL+1];
    ndrth_pkg::div_beat_t               chain_beat [NCELL+1];

    assign full      = (count_reg == CW'(MAX_TRIANGLES));
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ndrth_pkg::ST_IDLE) || !out_free;
    assign in_acc    = in_valid && !in_stall;
    assign load_item = in_acc && (mode != ndrth_pkg::MODE_QUERY);
    assign wr_vertex = in_acc && (mode == ndrth_pkg::MODE_VERTEX)
                       && (vertex_slot < ndrth_pkg::SLOT_COUNT) && !full;
    assign cfg_ready = 1'b1;
    assign lift      = (ndrth_pkg::LIFT_W'(probe_lift_reg) << LIFT_UP) >> LIFT_DN;

    assign exit_vld  = chain_vld[NCELL];
    assign take      = exit_vld && chain_beat[NCELL].cand && (chain_beat[NCELL].q < best_reg);

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        issue      = 1'b0;
        load_query = 1'b0;
        unique case (state_reg)
            ndrth_pkg::ST_IDLE:
            begin
                if (in_acc && mode == ndrth_pkg::MODE_QUERY)
                begin
                    state_next = ndrth_pkg::ST_SCAN;
                    scan_next  = '0;
                end
            end
            ndrth_pkg::ST_SCAN:
            begin
                if (scan_reg != count_reg)
                begin
                    issue     = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    state_next = ndrth_pkg::ST_DRAIN;
                end
            end
            ndrth_pkg::ST_DRAIN:
            begin
                if (pend_reg == '0)
                begin
                    state_next = ndrth_pkg::ST_DONE;
                end
            end
            ndrth_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    load_query = 1'b1;
                    state_next = ndrth_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ndrth_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (issue && !exit_vld)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!issue && exit_vld)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ndrth_pkg::ST_IDLE;
            scan_reg       <= '0;
            pend_reg       <= '0;
            count_reg      <= '0;
            probe_lift_reg <= 16'd6554;
            max_dist_reg   <= 31'd655294464;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            scan_reg   <= scan_next;
            pend_reg   <= pend_next;
            rd_vld_reg <= issue;
            out_valid_reg <= load_item || load_query || (out_valid_reg && out_stall);
            if (in_acc && mode == ndrth_pkg::MODE_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (in_acc && mode == ndrth_pkg::MODE_COMMIT && !full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ndrth_pkg::CFG_PROBE_LIFT: probe_lift_reg <= cfg_data[15:0];
                    ndrth_pkg::CFG_MAX_DIST:   max_dist_reg   <= cfg_data;
                    default:                   max_dist_reg   <= max_dist_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && mode == ndrth_pkg::MODE_QUERY)
        begin
            pt_reg.x     <= pos_x;
            pt_reg.y     <= (ndrth_pkg::COORD_W + 1)'(pos_y)
                            + $signed({5'b0, lift});
            pt_reg.z     <= pos_z;
            best_reg     <= max_dist_reg;
            best_hit_reg <= 1'b0;
            best_id_reg  <= '0;
        end
        else if (take)
        begin
            best_reg     <= chain_beat[NCELL].q;
            best_hit_reg <= 1'b1;
            best_id_reg  <= chain_beat[NCELL].id;
        end

        if (load_item)
        begin
            status_reg   <= (mode == ndrth_pkg::MODE_COMMIT && full)
                            ? ndrth_pkg::STATUS_FULL : ndrth_pkg::STATUS_OK;
            hit_reg      <= 1'b0;
            hit_id_reg   <= '0;
            hit_dist_reg <= '0;
        end
        else if (load_query)
        begin
            status_reg   <= ndrth_pkg::STATUS_QUERY;
            hit_reg      <= best_hit_reg;
            hit_id_reg   <= best_id_reg;
            hit_dist_reg <= best_hit_reg ? best_reg : '0;
        end
    end

    for (genvar s = 0; s < 3; s++)
    begin : g_slot
        logic wr_slot;
        assign wr_slot = wr_vertex && (vertex_slot == 2'(s));

        ndrth_ram #(.WIDTH(ndrth_pkg::COORD_W), .DEPTH(MAX_TRIANGLES)) u_ram_x (
            .clk     (clk),
            .wr_en   (wr_slot),
            .wr_addr (count_reg[AW-1:0]),
            .wr_data (pos_x),
            .rd_en   (issue),
            .rd_addr (scan_reg[AW-1:0]),
            .rd_data (rd_x[s])
        );

        ndrth_ram #(.WIDTH(ndrth_pkg::COORD_W), .DEPTH(MAX_TRIANGLES)) u_ram_y (
            .clk     (clk),
            .wr_en   (wr_slot),
            .wr_addr (count_reg[AW-1:0]),
            .wr_data (pos_y),
            .rd_en   (issue),
            .rd_addr (scan_reg[AW-1:0]),
            .rd_data (rd_y[s])
        );

        ndrth_ram #(.WIDTH(ndrth_pkg::COORD_W), .DEPTH(MAX_TRIANGLES)) u_ram_z (
            .clk     (clk),
            .wr_en   (wr_slot),
            .wr_addr (count_reg[AW-1:0]),
            .wr_data (pos_z),
            .rd_en   (issue),
            .rd_addr (scan_reg[AW-1:0]),
            .rd_data (rd_z[s])
        );
    end

    ndrth_ram #(.WIDTH(ndrth_pkg::ID_W), .DEPTH(MAX_TRIANGLES)) u_ram_id (
        .clk     (clk),
        .wr_en   (in_acc && mode == ndrth_pkg::MODE_COMMIT && !full),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (entry_id),
        .rd_en   (issue),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_data (rd_id)
    );

    always_comb
    begin
        tri_rd.ax = rd_x[0];
        tri_rd.ay = rd_y[0];
        tri_rd.az = rd_z[0];
        tri_rd.bx = rd_x[1];
        tri_rd.by = rd_y[1];
        tri_rd.bz = rd_z[1];
        tri_rd.cx = rd_x[2];
        tri_rd.cy = rd_y[2];
        tri_rd.cz = rd_z[2];
    end

    ndrth_geom u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (rd_vld_reg),
        .tri_in   (tri_rd),
        .in_id    (rd_id),
        .pt       (pt_reg),
        .out_vld  (chain_vld[0]),
        .out_beat (chain_beat[0])
    );

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        ndrth_div_cell #(.BIT(NCELL - 1 - k)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (chain_vld[k]),
            .in_beat  (chain_beat[k]),
            .out_vld  (chain_vld[k+1]),
            .out_beat (chain_beat[k+1])
        );
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign hit          = hit_reg;
    assign hit_id       = hit_id_reg;
    assign hit_distance = hit_dist_reg;

    // In-flight triangles never outnumber the stored ones.
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= count_reg)
        else $error("more triangles in flight than stored");

    // No triangle leaves the cell row once the scan is finished and drained.
    a_no_late_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ndrth_pkg::ST_IDLE || state_reg == ndrth_pkg::ST_DONE) |-> !exit_vld)
        else $error("triangle left the division row outside a query");

    // A finished query puts its answer beat out and frees the input.
    a_query_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ndrth_pkg::ST_DONE && out_free)
        |=> (out_valid_reg && status_reg == ndrth_pkg::STATUS_QUERY
             && state_reg == ndrth_pkg::ST_IDLE))
        else $error("query answer beat missing");

endmodule
